/* hdl/camera_pixel_to_world_transform_assert.svh */
// Assertion macros shared by the camera pixel to world transform RTL
`ifndef CAMERA_PIXEL_TO_WORLD_TRANSFORM_ASSERT_SVH
`define CAMERA_PIXEL_TO_WORLD_TRANSFORM_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising clock edge outside reset
`define CPW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Check that a condition never holds outside reset
`define CPW_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);
`else
`define CPW_ASSERT(lbl, prop, msg)
`define CPW_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

/* hdl/cpw_pkg.sv */
// Types, constants and helper functions for the camera pixel to world transform
package cpw_pkg;

  // Field types
  typedef logic signed [31:0] q16_t;
  typedef logic        [31:0] uq16_t;
  typedef logic        [15:0] angle_t;
  typedef logic        [11:0] pix_t;
  typedef logic        [23:0] scale_t;

  // APB geometry
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Register indexes
  typedef enum logic [1:0] {
    REG_CENTER_X     = 2'd0,
    REG_CENTER_Y     = 2'd1,
    REG_MPP          = 2'd2,
    REG_FRAME_OFFSET = 2'd3
  } reg_idx_e;

  // Register reset values
  localparam pix_t   CENTER_X_RST     = 12'd320;
  localparam pix_t   CENTER_Y_RST     = 12'd240;
  localparam scale_t MPP_RST          = 24'd4439;
  localparam angle_t FRAME_OFFSET_RST = 16'd0;

  // Quarter turn in binary angle units
  localparam angle_t QUARTER_TURN = 16'h4000;

  // Q2.30 constants
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef struct packed {
    pix_t   center_x;
    pix_t   center_y;
    scale_t mpp;
    angle_t frame_offset;
  } cfg_t;

  // Sine and cosine of one angle: quarter-wave magnitude and sign
  typedef struct packed {
    logic        sin_neg;
    logic [30:0] sin_mag;
    logic        cos_neg;
    logic [30:0] cos_mag;
  } trig_t;

  // Sine of a first-quarter phase, Q2.30, evaluated at elaboration for the table
  function automatic logic [30:0] quarter_sine(input longint p, input int qbits);
    longint x;
    longint x2;
    longint t;
    longint r;
    x  = (p * HALF_PI_Q30) >>> qbits;
    x2 = (x * x) >>> 30;
    t  = ONE_Q30 - x2 / 110;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >>> 30) / 6;
    r  = (x * t) >>> 30;
    if (r > ONE_Q30) begin
      r = ONE_Q30;
    end
    if (r < 0) begin
      r = 0;
    end
    return r[30:0];
  endfunction

  // Apply the quadrant sign to a table magnitude
  function automatic q16_t apply_sign(input logic neg, input logic [30:0] mag);
    q16_t m;
    m = signed'({1'b0, mag});
    return neg ? -m : m;
  endfunction

  // Round a product slice (bits 61:29 of a Q16.16 x Q2.30 product) to Q16.16
  function automatic logic [31:0] round_prod(input logic [32:0] v);
    return v[32:1] + {31'd0, v[0]};
  endfunction

endpackage

/* hdl/cpw_stream_if.sv */
// Valid/ready channel interfaces for detection transactions and world results
interface cpw_in_if;
  logic           valid;
  logic           ready;
  cpw_pkg::q16_t  drone_x;
  cpw_pkg::q16_t  drone_y;
  cpw_pkg::angle_t heading;
  cpw_pkg::pix_t  pixel_x;
  cpw_pkg::pix_t  pixel_y;
  cpw_pkg::uq16_t altitude;

  modport source (output valid, drone_x, drone_y, heading, pixel_x, pixel_y, altitude,
                  input ready);
  modport sink (input valid, drone_x, drone_y, heading, pixel_x, pixel_y, altitude,
                output ready);
endinterface

interface cpw_out_if;
  logic           valid;
  logic           ready;
  cpw_pkg::q16_t  world_x;
  cpw_pkg::q16_t  world_y;
  cpw_pkg::q16_t  camera_x;
  cpw_pkg::q16_t  camera_y;
  cpw_pkg::uq16_t height;

  modport source (output valid, world_x, world_y, camera_x, camera_y, height,
                  input ready);
  modport sink (input valid, world_x, world_y, camera_x, camera_y, height,
                output ready);
endinterface

/* hdl/cpw_apb_regs.sv */
// APB configuration registers: image centre, pixel scale and frame offset angle
module cpw_apb_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cpw_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [cpw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [cpw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready,
  output cpw_pkg::cfg_t                     cfg_o
);

  cpw_pkg::cfg_t    cfg_q;
  cpw_pkg::reg_idx_e reg_idx;
  logic             wr_en;

  assign pready  = 1'b1;
  assign reg_idx = cpw_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Write the addressed register on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x     <= cpw_pkg::CENTER_X_RST;
      cfg_q.center_y     <= cpw_pkg::CENTER_Y_RST;
      cfg_q.mpp          <= cpw_pkg::MPP_RST;
      cfg_q.frame_offset <= cpw_pkg::FRAME_OFFSET_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        cpw_pkg::REG_CENTER_X:     cfg_q.center_x     <= pwdata[11:0];
        cpw_pkg::REG_CENTER_Y:     cfg_q.center_y     <= pwdata[11:0];
        cpw_pkg::REG_MPP:          cfg_q.mpp          <= pwdata[23:0];
        cpw_pkg::REG_FRAME_OFFSET: cfg_q.frame_offset <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      cpw_pkg::REG_CENTER_X:     prdata = {20'd0, cfg_q.center_x};
      cpw_pkg::REG_CENTER_Y:     prdata = {20'd0, cfg_q.center_y};
      cpw_pkg::REG_MPP:          prdata = {8'd0, cfg_q.mpp};
      cpw_pkg::REG_FRAME_OFFSET: prdata = {16'd0, cfg_q.frame_offset};
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/cpw_sine_rom.sv */
// Quarter-wave sine table with registered sine and cosine lookups of one angle
module cpw_sine_rom #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  cpw_pkg::angle_t angle_i,
  output cpw_pkg::trig_t  trig_o
);

  localparam int QBITS = SINE_TABLE_BITS - 2;
  localparam int QLEN  = 1 << QBITS;
  localparam int AW    = QBITS + 1;

  logic [30:0]                qtab [0:QLEN];
  cpw_pkg::angle_t            angle_c;
  logic [SINE_TABLE_BITS-1:0] idx_s;
  logic [SINE_TABLE_BITS-1:0] idx_c;
  logic [AW-1:0]              addr_s;
  logic [AW-1:0]              addr_c;
  cpw_pkg::trig_t             trig_q;

  // Build the first-quarter table, endpoints included
  for (genvar k = 0; k <= QLEN; k++) begin : g_qtab
    assign qtab[k] = cpw_pkg::quarter_sine(longint'(k), QBITS);
  end

  // Fold each table index into the first quarter
  always_comb begin
    angle_c = angle_i + cpw_pkg::QUARTER_TURN;
    idx_s   = angle_i[15 -: SINE_TABLE_BITS];
    idx_c   = angle_c[15 -: SINE_TABLE_BITS];
    addr_s  = idx_s[QBITS] ? AW'(QLEN) - AW'(idx_s[QBITS-1:0]) : AW'(idx_s[QBITS-1:0]);
    addr_c  = idx_c[QBITS] ? AW'(QLEN) - AW'(idx_c[QBITS-1:0]) : AW'(idx_c[QBITS-1:0]);
  end

  // Register the lookups; the upper half turn is negative
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q.sin_mag <= qtab[addr_s];
      trig_q.sin_neg <= idx_s[SINE_TABLE_BITS-1];
      trig_q.cos_mag <= qtab[addr_c];
      trig_q.cos_neg <= idx_c[SINE_TABLE_BITS-1];
    end
  end

  assign trig_o = trig_q;

endmodule

/* hdl/camera_pixel_to_world_transform.sv */
// Camera pixel to world transform top level: four-stage pipeline with APB registers
// Stages in order: table lookup, scale, multiply, sum; each registers its results.
// Throughput: one transaction per cycle; a full stage holds while the next cannot advance.
// A stalled result register leaves earlier stages free to fill their bubbles.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads register defaults.
`include "camera_pixel_to_world_transform_assert.svh"

module camera_pixel_to_world_transform #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cpw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cpw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cpw_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  cpw_in_if.sink                         in_i,
  cpw_out_if.source                      out_o
);

  cpw_pkg::cfg_t   cfg;
  cpw_pkg::angle_t angle_a;
  cpw_pkg::trig_t  trig_a;
  cpw_pkg::trig_t  trig_b;

  logic en1, en2, en3, en4;
  logic in_fire;
  logic v1_q, v2_q, v3_q, v4_q;

  // Stage 1
  cpw_pkg::q16_t   xe1_q, ye1_q;
  cpw_pkg::uq16_t  alt1_q;
  logic signed [12:0] offx1_q, offy1_q;
  logic signed [24:0] mpp_s;
  logic signed [37:0] scale_x, scale_y;

  // Stage 2
  cpw_pkg::q16_t   xe2_q, ye2_q, cx2_q, cy2_q;
  cpw_pkg::q16_t   ca2_q, sa2_q, cb2_q, sb2_q;
  cpw_pkg::uq16_t  alt2_q;
  logic signed [63:0] m_xecb, m_yesb, m_xesb, m_yecb;
  logic signed [63:0] m_cxca, m_cysa, m_cyca, m_cxsa;

  // Stage 3
  logic [32:0]     p_xecb_q, p_yesb_q, p_xesb_q, p_yecb_q;
  logic [32:0]     p_cxca_q, p_cysa_q, p_cyca_q, p_cxsa_q;
  cpw_pkg::q16_t   cx3_q, cy3_q;
  cpw_pkg::uq16_t  alt3_q;

  // Stage 4 (result register)
  cpw_pkg::q16_t   wx4_q, wy4_q, cx4_q, cy4_q;
  cpw_pkg::uq16_t  alt4_q;

  cpw_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance a stage when it is empty or the stage after it advances
  assign en4     = !v4_q || out_o.ready;
  assign en3     = !v3_q || en4;
  assign en2     = !v2_q || en3;
  assign en1     = !v1_q || en2;
  assign in_i.ready = en1;
  assign in_fire = in_i.valid && en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Stage 1: pixel offsets and trig table lookups
  assign angle_a = in_i.heading - cfg.frame_offset;

  cpw_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom_a (
    .clk_i   (clk_i),
    .en_i    (en1),
    .angle_i (angle_a),
    .trig_o  (trig_a)
  );

  cpw_sine_rom #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_rom_b (
    .clk_i   (clk_i),
    .en_i    (en1),
    .angle_i (cfg.frame_offset),
    .trig_o  (trig_b)
  );

  always_ff @(posedge clk_i) begin
    if (en1) begin
      xe1_q   <= in_i.drone_x;
      ye1_q   <= in_i.drone_y;
      alt1_q  <= in_i.altitude;
      offx1_q <= {1'b0, in_i.pixel_x} - {1'b0, cfg.center_x};
      offy1_q <= {1'b0, cfg.center_y} - {1'b0, in_i.pixel_y};
    end
  end

  // Stage 2: scale offsets to metres and sign the trig values
  assign mpp_s   = signed'({1'b0, cfg.mpp});
  assign scale_x = offx1_q * mpp_s;
  assign scale_y = offy1_q * mpp_s;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      cx2_q  <= 32'((scale_x + 38'sd128) >>> 8);
      cy2_q  <= 32'((scale_y + 38'sd128) >>> 8);
      xe2_q  <= xe1_q;
      ye2_q  <= ye1_q;
      alt2_q <= alt1_q;
      ca2_q  <= cpw_pkg::apply_sign(trig_a.cos_neg, trig_a.cos_mag);
      sa2_q  <= cpw_pkg::apply_sign(trig_a.sin_neg, trig_a.sin_mag);
      cb2_q  <= cpw_pkg::apply_sign(trig_b.cos_neg, trig_b.cos_mag);
      sb2_q  <= cpw_pkg::apply_sign(trig_b.sin_neg, trig_b.sin_mag);
    end
  end

  // Stage 3: rotation products, keep the bits that survive rounding
  assign m_xecb = xe2_q * cb2_q;
  assign m_yesb = ye2_q * sb2_q;
  assign m_xesb = xe2_q * sb2_q;
  assign m_yecb = ye2_q * cb2_q;
  assign m_cxca = cx2_q * ca2_q;
  assign m_cysa = cy2_q * sa2_q;
  assign m_cyca = cy2_q * ca2_q;
  assign m_cxsa = cx2_q * sa2_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      p_xecb_q <= m_xecb[61:29];
      p_yesb_q <= m_yesb[61:29];
      p_xesb_q <= m_xesb[61:29];
      p_yecb_q <= m_yecb[61:29];
      p_cxca_q <= m_cxca[61:29];
      p_cysa_q <= m_cysa[61:29];
      p_cyca_q <= m_cyca[61:29];
      p_cxsa_q <= m_cxsa[61:29];
      cx3_q    <= cx2_q;
      cy3_q    <= cy2_q;
      alt3_q   <= alt2_q;
    end
  end

  // Stage 4: round each product and sum into world coordinates
  always_ff @(posedge clk_i) begin
    if (en4) begin
      wx4_q  <= cpw_pkg::round_prod(p_cxca_q) + cpw_pkg::round_prod(p_cysa_q)
              + cpw_pkg::round_prod(p_xecb_q) - cpw_pkg::round_prod(p_yesb_q);
      wy4_q  <= cpw_pkg::round_prod(p_cyca_q) - cpw_pkg::round_prod(p_cxsa_q)
              + cpw_pkg::round_prod(p_xesb_q) + cpw_pkg::round_prod(p_yecb_q);
      cx4_q  <= cx3_q;
      cy4_q  <= cy3_q;
      alt4_q <= alt3_q;
    end
  end

  assign out_o.valid    = v4_q;
  assign out_o.world_x  = wx4_q;
  assign out_o.world_y  = wy4_q;
  assign out_o.camera_x = cx4_q;
  assign out_o.camera_y = cy4_q;
  assign out_o.height   = alt4_q;

  `CPW_ASSERT(a_accept_fills_s1, in_fire |=> v1_q, "accepted transaction did not enter stage 1")
  `CPW_ASSERT(a_stall_holds_s1, v1_q && !en1 |=> v1_q, "stalled stage 1 lost its transaction")
  `CPW_ASSERT(a_bubble_fills_s4, v3_q && !v4_q |=> v4_q, "stage 3 did not move into empty result register")
  `CPW_ASSERT_NEVER(a_ready_low_not_full, !en1 && !(v1_q && v2_q && v3_q && v4_q), "input stalled with a bubble in the pipeline")

endmodule
